FILE: rtl/utfbom_pkg.sv
// Shared types, codes and unit codec functions for the UTF transcoder.
// Used by utfbom_front, utfbom_serial and utf_transcoder_bom_detect.
`default_nettype none

package utfbom_pkg;

  // input decoding modes
  localparam logic [2:0] MODE_UTF8  = 3'd0;
  localparam logic [2:0] MODE_U16LE = 3'd1;
  localparam logic [2:0] MODE_U16BE = 3'd2;
  localparam logic [2:0] MODE_U32LE = 3'd3;
  localparam logic [2:0] MODE_U32BE = 3'd4;

  // output encodings (register codes)
  localparam logic [2:0] ENC_UTF8     = 3'd0;
  localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
  localparam logic [2:0] ENC_U16LE    = 3'd2;
  localparam logic [2:0] ENC_U16BE    = 3'd3;
  localparam logic [2:0] ENC_U32LE    = 3'd4;
  localparam logic [2:0] ENC_U32BE    = 3'd5;

  localparam int NUM_SLOTS = 5;              // char slots per record
  localparam int NUM_SEGS  = NUM_SLOTS + 1;  // mark plus char slots

  // one pass of the unit assembler
  typedef struct packed {
    logic        emit;
    logic [15:0] cp;
    logic [1:0]  ucnt;
    logic [23:0] ub;
  } feed_t;

  // output work for one input word: seg[0] mark, seg[k+1] char slot k
  typedef struct packed {
    logic [NUM_SEGS-1:0]             seg;
    logic [NUM_SLOTS-1:0][15:0]      cp;
  } rec_t;

  typedef struct packed {
    logic in_v;
    logic proc;
  } front_stat_t;

  function automatic logic [15:0] decode_unit(logic [2:0] mode, logic [3:0][7:0] u);
    logic [15:0] cp;
    case (mode)
      MODE_UTF8: begin
        if (!u[0][7]) cp = {8'h00, u[0]};
        else          cp = {5'b0, u[0][4:0], u[1][5:0]};
      end
      MODE_U16LE: cp = {u[1], u[0]};
      MODE_U16BE: cp = {u[0], u[1]};
      MODE_U32LE: cp = {u[1], u[0]};
      MODE_U32BE: cp = {u[2], u[3]};
      default:    cp = 16'h0000;
    endcase
    return cp;
  endfunction

  // held bytes of a partial unit, zeros beyond the fill count
  function automatic logic [3:0][7:0] held_bytes(logic [23:0] ub, logic [1:0] ucnt);
    logic [3:0][7:0] u;
    u = '0;
    if (ucnt > 2'd0) u[0] = ub[7:0];
    if (ucnt > 2'd1) u[1] = ub[15:8];
    if (ucnt > 2'd2) u[2] = ub[23:16];
    return u;
  endfunction

  function automatic feed_t feed(logic [2:0] mode, logic [1:0] ucnt, logic [23:0] ub,
                                 logic [7:0] b);
    feed_t           r;
    logic [2:0]      need;
    logic [2:0]      cnt1;
    logic [3:0][7:0] u;
    case (mode)
      MODE_UTF8:               need = (ucnt == 2'd0 && !b[7]) ? 3'd1 : 3'd2;
      MODE_U16LE, MODE_U16BE:  need = 3'd2;
      default:                 need = 3'd4;
    endcase
    cnt1 = {1'b0, ucnt} + 3'd1;
    u    = held_bytes(ub, ucnt);
    if (cnt1 >= need) begin
      u[ucnt] = b;
      r.emit  = 1'b1;
      r.cp    = decode_unit(mode, u);
      r.ucnt  = 2'd0;
      r.ub    = '0;
    end else begin
      r.emit = 1'b0;
      r.cp   = 16'h0000;
      r.ucnt = ucnt + 2'd1;
      r.ub   = ub;
      case (ucnt)
        2'd0:    r.ub[7:0]   = b;
        2'd1:    r.ub[15:8]  = b;
        default: r.ub[23:16] = b;
      endcase
    end
    return r;
  endfunction

  // pad a trailing partial unit with zeros
  function automatic feed_t flush(logic [2:0] mode, logic [1:0] ucnt, logic [23:0] ub);
    feed_t r;
    r.emit = (ucnt != 2'd0);
    r.cp   = decode_unit(mode, held_bytes(ub, ucnt));
    r.ucnt = 2'd0;
    r.ub   = '0;
    return r;
  endfunction

  function automatic logic [2:0] enc_len(logic [2:0] enc, logic [15:0] cp);
    logic [2:0] n;
    case (enc)
      ENC_UTF8, ENC_UTF8_BOM: n = (cp < 16'h0080) ? 3'd1 : 3'd2;
      ENC_U16LE, ENC_U16BE:   n = 3'd2;
      ENC_U32LE, ENC_U32BE:   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] enc_byte(logic [2:0] enc, logic [15:0] cp, logic [1:0] j);
    logic [7:0] v;
    case (enc)
      ENC_UTF8, ENC_UTF8_BOM: begin
        if (cp < 16'h0080)  v = cp[7:0];
        else if (j == 2'd0) v = {3'b110, cp[10:6]};
        else                v = {2'b10, cp[5:0]};
      end
      ENC_U16LE: v = (j == 2'd0) ? cp[7:0] : cp[15:8];
      ENC_U16BE: v = (j == 2'd0) ? cp[15:8] : cp[7:0];
      ENC_U32LE: begin
        case (j)
          2'd0:    v = cp[7:0];
          2'd1:    v = cp[15:8];
          default: v = 8'h00;
        endcase
      end
      ENC_U32BE: begin
        case (j)
          2'd2:    v = cp[15:8];
          2'd3:    v = cp[7:0];
          default: v = 8'h00;
        endcase
      end
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] mark_len(logic [2:0] enc);
    logic [2:0] n;
    case (enc)
      ENC_UTF8_BOM:          n = 3'd3;
      ENC_U16LE, ENC_U16BE:  n = 3'd2;
      ENC_U32LE, ENC_U32BE:  n = 3'd4;
      default:               n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] mark_byte(logic [2:0] enc, logic [1:0] j);
    logic [7:0] v;
    case (enc)
      ENC_UTF8_BOM: begin
        case (j)
          2'd0:    v = 8'hEF;
          2'd1:    v = 8'hBB;
          default: v = 8'hBF;
        endcase
      end
      ENC_U16LE, ENC_U32LE: begin
        case (j)
          2'd0:    v = 8'hFF;
          2'd1:    v = 8'hFE;
          default: v = 8'h00;
        endcase
      end
      ENC_U16BE: v = (j == 2'd0) ? 8'hFE : 8'hFF;
      ENC_U32BE: begin
        case (j)
          2'd2:    v = 8'hFE;
          2'd3:    v = 8'hFF;
          default: v = 8'h00;
        endcase
      end
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/utfbom_front.sv
// Input register, mark detection and unit assembly; builds one output record per word.
// Depends on utfbom_pkg.
`default_nettype none

module utfbom_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [2:0]          enc,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,
  input  wire logic                s_tlast,
  input  wire logic                ser_rdy,
  output logic                     load,
  output utfbom_pkg::rec_t         rec,
  output utfbom_pkg::front_stat_t  stat
);
  import utfbom_pkg::*;

  // input register
  logic       in_v;
  logic [7:0] ib;
  logic       il;

  // stream state
  logic [3:0][7:0] win;
  logic [2:0]      wcnt;
  logic            done;
  logic [2:0]      mode;
  logic [1:0]      ucnt;
  logic [23:0]     ub;

  logic [3:0][7:0] win_next;
  logic [2:0]      wcnt_next;
  logic            done_next;
  logic [2:0]      mode_next;
  logic [1:0]      ucnt_next;
  logic [23:0]     ub_next;

  logic [2:0]                 wcnt1;
  logic [2:0]                 dmode;
  logic [2:0]                 skip;
  logic                       mark_en;
  logic [NUM_SLOTS-1:0]       slot_v;
  logic [NUM_SLOTS-1:0][15:0] slot_cp;
  logic [1:0]                 st_cnt;
  logic [23:0]                st_ub;
  feed_t                      f;
  feed_t                      fl;
  logic                       has;
  logic                       proc;

  always_comb begin
    win_next  = win;
    wcnt_next = wcnt;
    done_next = done;
    mode_next = mode;
    wcnt1     = wcnt + 3'd1;
    dmode     = MODE_UTF8;
    skip      = 3'd0;
    mark_en   = 1'b0;
    slot_v    = '0;
    slot_cp   = '0;
    st_cnt    = ucnt;
    st_ub     = ub;
    f         = '0;
    if (!done) begin
      if (wcnt < 3'd4) win_next[wcnt[1:0]] = ib;
      wcnt_next = wcnt1;
      if (wcnt1 >= 3'd4 || il) begin
        // marks tried in priority order; each needs all its bytes present
        if (wcnt1 >= 3'd3 && win_next[0] == 8'hEF && win_next[1] == 8'hBB &&
            win_next[2] == 8'hBF) begin
          dmode = MODE_UTF8;  skip = 3'd3;
        end else if (wcnt1 >= 3'd4 && win_next[0] == 8'hFF && win_next[1] == 8'hFE &&
                     win_next[2] == 8'h00 && win_next[3] == 8'h00) begin
          dmode = MODE_U32LE; skip = 3'd4;
        end else if (wcnt1 >= 3'd4 && win_next[0] == 8'h00 && win_next[1] == 8'h00 &&
                     win_next[2] == 8'hFE && win_next[3] == 8'hFF) begin
          dmode = MODE_U32BE; skip = 3'd4;
        end else if (wcnt1 >= 3'd2 && win_next[0] == 8'hFF && win_next[1] == 8'hFE) begin
          dmode = MODE_U16LE; skip = 3'd2;
        end else if (wcnt1 >= 3'd2 && win_next[0] == 8'hFE && win_next[1] == 8'hFF) begin
          dmode = MODE_U16BE; skip = 3'd2;
        end
        mark_en   = 1'b1;
        done_next = 1'b1;
        mode_next = dmode;
        st_cnt    = 2'd0;
        st_ub     = '0;
        // replay the window bytes that follow the mark
        for (int i = 0; i < 4; i++) begin
          if (3'(i) >= skip && 3'(i) < wcnt1) begin
            f          = feed(dmode, st_cnt, st_ub, win_next[i]);
            slot_v[i]  = f.emit;
            slot_cp[i] = f.cp;
            st_cnt     = f.ucnt;
            st_ub      = f.ub;
          end
        end
      end
    end else begin
      f          = feed(mode, ucnt, ub, ib);
      slot_v[0]  = f.emit;
      slot_cp[0] = f.cp;
      st_cnt     = f.ucnt;
      st_ub      = f.ub;
    end
    ucnt_next = st_cnt;
    ub_next   = st_ub;
    fl        = flush(mode_next, st_cnt, st_ub);
    if (il) begin
      slot_v[NUM_SLOTS-1]  = fl.emit;
      slot_cp[NUM_SLOTS-1] = fl.cp;
      wcnt_next = 3'd0;
      done_next = 1'b0;
      mode_next = MODE_UTF8;
      ucnt_next = 2'd0;
    end
  end

  always_comb begin
    rec.cp     = slot_cp;
    rec.seg[0] = mark_en && (mark_len(enc) != 3'd0);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      rec.seg[k+1] = slot_v[k] && (enc_len(enc, slot_cp[k]) != 3'd0);
    end
  end

  assign has       = |rec.seg;
  assign proc      = in_v && (!has || ser_rdy);
  assign load      = proc && has;
  assign s_tready  = !in_v || proc;
  assign stat.in_v = in_v;
  assign stat.proc = proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      wcnt <= 3'd0;
      done <= 1'b0;
      mode <= MODE_UTF8;
      ucnt <= 2'd0;
    end else begin
      if (s_tready) in_v <= s_tvalid;
      if (proc) begin
        wcnt <= wcnt_next;
        done <= done_next;
        mode <= mode_next;
        ucnt <= ucnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ib <= s_tdata;
      il <= s_tlast;
    end
    if (proc) begin
      win <= win_next;
      ub  <= ub_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utfbom_serial.sv
// Byte serializer: walks the mark and char slots of a record, one output word per cycle while m_tready allows.
// Depends on utfbom_pkg.
`default_nettype none

module utfbom_serial (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        enc,
  input  wire logic              load,
  input  wire utfbom_pkg::rec_t  rec,
  output logic                   ser_rdy,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);
  import utfbom_pkg::*;

  logic [NUM_SEGS-1:0]        pend;
  logic [NUM_SLOTS-1:0][15:0] cps;
  logic [1:0]                 j;

  logic [NUM_SEGS-1:0] cur;
  logic [NUM_SEGS-1:0] rest;
  logic [2:0]          idx;
  logic [15:0]         cp_sel;
  logic [2:0]          len;
  logic [7:0]          byte_sel;
  logic                seg_end;
  logic                fin;
  logic                emit;

  always_comb begin
    idx = 3'd0;
    for (int k = NUM_SEGS - 1; k >= 0; k--) begin
      if (pend[k]) idx = 3'(k);
    end
    cur  = pend & (~pend + NUM_SEGS'(1));
    rest = pend & ~cur;
    case (idx)
      3'd1:    cp_sel = cps[0];
      3'd2:    cp_sel = cps[1];
      3'd3:    cp_sel = cps[2];
      3'd4:    cp_sel = cps[3];
      3'd5:    cp_sel = cps[4];
      default: cp_sel = 16'h0000;
    endcase
    if (idx == 3'd0) begin
      len      = mark_len(enc);
      byte_sel = mark_byte(enc, j);
    end else begin
      len      = enc_len(enc, cp_sel);
      byte_sel = enc_byte(enc, cp_sel, j);
    end
  end

  assign seg_end = ({1'b0, j} == len - 3'd1);
  assign fin     = seg_end && (rest == '0);
  assign emit    = (pend != '0) && (!m_tvalid || m_tready);
  assign ser_rdy = (pend == '0) || (emit && fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= '0;
      j        <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load) begin
        pend <= rec.seg;
        j    <= 2'd0;
      end else if (emit) begin
        if (seg_end) begin
          pend <= rest;
          j    <= 2'd0;
        end else begin
          j <= j + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cps <= rec.cp;
    if (emit) begin
      m_tdata <= byte_sel;
      m_tlast <= fin;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf_transcoder_bom_detect.sv
// Top level of the UTF transcoder with byte-order-mark detection.
// Instantiates utfbom_front and utfbom_serial; depends on utfbom_pkg.
`default_nettype none

// Byte stream in, byte stream out. The first up to four bytes of a stream are
// held back to look for a byte-order mark (UTF-8, then UTF-32LE, UTF-32BE,
// UTF-16LE, UTF-16BE; no mark means UTF-8). From then on every input unit is
// decoded to a 16-bit code point and re-encoded in the encoding held in the
// out_encoding register (cfg_wdata: 0 UTF-8, 1 UTF-8 with mark, 2 UTF-16LE,
// 3 UTF-16BE, 4 UTF-32LE, 5 UTF-32BE, 6/7 drop everything). UTF-8 is decoded
// in its one- and two-byte forms only; a stream ending on a partial unit gets
// it zero-padded. The output mark is sent when detection fires, ahead of all
// characters. s_tlast ends a stream and returns all stream state to reset;
// m_tlast flags the final output word caused by one input word, and a word
// that causes no output produces nothing on the master side.
// Rate: one output word per cycle from the serializer while m_tready allows.
// A word yields 0 to 4 output bytes in steady state (4 for UTF-32 output), up
// to 20 on the word that fires detection, and is passed on only once the
// serializer has sent the bytes of the word before; words that yield no output
// need not wait. Input to output runs through three registers (input, record, output).
// Write out_encoding only while the block is idle.
module utf_transcoder_bom_detect (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,   // out_encoding
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,     // [7:0] in_byte
  input  wire logic       s_tlast,     // in_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,     // [7:0] out_byte
  output logic            m_tlast      // out_last
);
  import utfbom_pkg::*;

  logic        [2:0] enc;
  logic              load;
  logic              ser_rdy;
  rec_t              rec;
  front_stat_t       stat;

  // out_encoding register
  always_ff @(posedge clk) begin
    if (rst) begin
      enc <= ENC_UTF8;
    end else if (cfg_we) begin
      enc <= cfg_wdata;
    end
  end

  // detection, unit assembly and decode into a per-word record
  utfbom_front u_front (
    .clk      (clk),
    .rst      (rst),
    .enc      (enc),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .ser_rdy  (ser_rdy),
    .load     (load),
    .rec      (rec),
    .stat     (stat)
  );

  // mark and character bytes out, one per cycle while m_tready allows
  utfbom_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .enc      (enc),
    .load     (load),
    .rec      (rec),
    .ser_rdy  (ser_rdy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  // a record is only handed over when the serializer can take it
  a_load_ready: assert property (@(posedge clk) disable iff (rst) load |-> ser_rdy)
    else $error("record loaded while serializer busy");

  // records with nothing to send are never loaded
  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |-> (rec.seg != '0))
    else $error("empty record loaded");

  // an accepted word always lands in the input register
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> stat.in_v)
    else $error("accepted word lost");

  // a held word that cannot advance blocks the slave side
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (stat.in_v && !stat.proc) |-> !s_tready)
    else $error("input accepted over a stalled word");
`endif

endmodule

`default_nettype wire

FILE: verif/utfbom_scoreboard.sv
// Scoreboard for utf_transcoder_bom_detect: predicts every output word from the accepted
// input words and the out_encoding register, then checks the master side in order.
// Depends on utfbom_pkg for the decoding mode and output encoding codes.
module utfbom_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  output int         errors,
  output int         pending
);
  import utfbom_pkg::*;

  localparam int MAX_WORDS = 20;  // most output words one input word can cause

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t   expected_out[$];
  logic [7:0]  bom_win [4];
  int          win_fill;
  bit          bom_checked;
  logic [2:0]  src_mode;
  logic [23:0] part_bytes;
  int          part_fill;
  logic [2:0]  out_enc;
  logic [7:0]  step_out [MAX_WORDS];
  int          step_n;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic emit(input logic [7:0] b);
    if (step_n < MAX_WORDS) begin
      step_out[step_n] = b;
      step_n++;
    end
  endtask

  // u holds the unit bytes, first byte lowest, missing bytes zero
  function automatic logic [15:0] unit_cp(input logic [2:0] mode, input logic [31:0] u);
    case (mode)
      MODE_UTF8:              return u[7] ? {5'b0, u[4:0], u[13:8]} : {8'h00, u[7:0]};
      MODE_U16LE, MODE_U32LE: return u[15:0];
      MODE_U16BE:             return {u[7:0], u[15:8]};
      MODE_U32BE:             return {u[23:16], u[31:24]};
      default:                return 16'h0000;
    endcase
  endfunction

  task automatic encode_char(input logic [15:0] cp);
    case (out_enc)
      ENC_UTF8, ENC_UTF8_BOM: begin
        if (cp < 16'h0080) begin
          emit(cp[7:0]);
        end else begin
          emit({3'b110, cp[10:6]});  // bits above 10 are lost
          emit({2'b10, cp[5:0]});
        end
      end
      ENC_U16LE: begin
        emit(cp[7:0]);
        emit(cp[15:8]);
      end
      ENC_U16BE: begin
        emit(cp[15:8]);
        emit(cp[7:0]);
      end
      ENC_U32LE: begin
        emit(cp[7:0]);
        emit(cp[15:8]);
        emit(8'h00);
        emit(8'h00);
      end
      ENC_U32BE: begin
        emit(8'h00);
        emit(8'h00);
        emit(cp[15:8]);
        emit(cp[7:0]);
      end
      default: ;  // codes 6 and 7 drop everything
    endcase
  endtask

  task automatic take_byte(input logic [7:0] b);
    int          need;
    logic [31:0] u;
    if (src_mode == MODE_UTF8) need = (part_fill == 0 && !b[7]) ? 1 : 2;
    else if (src_mode == MODE_U16LE || src_mode == MODE_U16BE) need = 2;
    else need = 4;
    if (part_fill + 1 >= need) begin
      u = {8'h00, part_bytes};
      u[8*part_fill +: 8] = b;
      encode_char(unit_cp(src_mode, u));
      part_bytes = '0;
      part_fill = 0;
    end else begin
      part_bytes[8*part_fill +: 8] = b;
      part_fill++;
    end
  endtask

  task automatic flush_part();
    if (part_fill != 0) encode_char(unit_cp(src_mode, {8'h00, part_bytes}));
    part_bytes = '0;
    part_fill = 0;
  endtask

  task automatic clear_stream();
    win_fill = 0;
    bom_checked = 0;
    src_mode = MODE_UTF8;
    part_bytes = '0;
    part_fill = 0;
  endtask

  task automatic run_detect();
    int skip;
    int i;
    skip = 0;
    src_mode = MODE_UTF8;
    if (win_fill >= 3 && bom_win[0] == 8'hEF && bom_win[1] == 8'hBB && bom_win[2] == 8'hBF) begin
      skip = 3;
    end else if (win_fill >= 4 && bom_win[0] == 8'hFF && bom_win[1] == 8'hFE &&
                 bom_win[2] == 8'h00 && bom_win[3] == 8'h00) begin
      src_mode = MODE_U32LE;
      skip = 4;
    end else if (win_fill >= 4 && bom_win[0] == 8'h00 && bom_win[1] == 8'h00 &&
                 bom_win[2] == 8'hFE && bom_win[3] == 8'hFF) begin
      src_mode = MODE_U32BE;
      skip = 4;
    end else if (win_fill >= 2 && bom_win[0] == 8'hFF && bom_win[1] == 8'hFE) begin
      src_mode = MODE_U16LE;
      skip = 2;
    end else if (win_fill >= 2 && bom_win[0] == 8'hFE && bom_win[1] == 8'hFF) begin
      src_mode = MODE_U16BE;
      skip = 2;
    end
    bom_checked = 1;
    case (out_enc)
      ENC_UTF8_BOM: begin
        emit(8'hEF);
        emit(8'hBB);
        emit(8'hBF);
      end
      ENC_U16LE: begin
        emit(8'hFF);
        emit(8'hFE);
      end
      ENC_U16BE: begin
        emit(8'hFE);
        emit(8'hFF);
      end
      ENC_U32LE: begin
        emit(8'hFF);
        emit(8'hFE);
        emit(8'h00);
        emit(8'h00);
      end
      ENC_U32BE: begin
        emit(8'h00);
        emit(8'h00);
        emit(8'hFE);
        emit(8'hFF);
      end
      default: ;
    endcase
    for (i = skip; i < win_fill && i < 4; i++) take_byte(bom_win[i]);
  endtask

  task automatic transcode_word(input logic [7:0] b, input logic last);
    int        i;
    out_word_t w;
    step_n = 0;
    if (!bom_checked) begin
      if (win_fill < 4) bom_win[win_fill] = b;
      win_fill++;
      if (win_fill >= 4 || last) run_detect();
    end else begin
      take_byte(b);
    end
    if (last) begin
      flush_part();
      clear_stream();
    end
    for (i = 0; i < step_n; i++) begin
      w.data = step_out[i];
      w.last = (i == step_n - 1);
      expected_out.push_back(w);
    end
  endtask

  // output side is checked before the input of the same edge is predicted
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      clear_stream();
      out_enc = ENC_UTF8;
      expected_out.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          report($sformatf("output word %02h with nothing expected", m_tdata));
        end else begin
          want = expected_out.pop_front();
          if (m_tdata !== want.data)
            report($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
          if (m_tlast !== want.last)
            report($sformatf("out_last %b, expected %b (byte %02h)", m_tlast, want.last,
                             want.data));
        end
      end
      if (cfg_we) out_enc = cfg_wdata;
      if (s_tvalid && s_tready) transcode_word(s_tdata, s_tlast);
    end
    pending <= expected_out.size();
  end

endmodule

FILE: verif/tb_utf_transcoder_bom_detect.sv
// Testbench top for utf_transcoder_bom_detect: drives text streams and register writes,
// randomizes both handshakes, and gives the verdict. Needs utfbom_pkg, the RTL and
// utfbom_scoreboard (which does all prediction and checking).
module tb_utf_transcoder_bom_detect;
  import utfbom_pkg::*;

  // codes 6 and 7 have no name in the package: the block drops all output
  localparam logic [2:0] ENC_DROP6 = 3'd6;
  localparam logic [2:0] ENC_DROP7 = 3'd7;

  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the block
  localparam int PHASE_WORDS  = 30;    // input words per register setting
  localparam int DRAIN_CYCLES = 8;     // covers the pipe for words with no output

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = ENC_UTF8;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int errors;
  int pending;
  int stall_cycles;
  int in_count;
  int out_count;
  int stream_count;

  bit hold_req;    // set by the sender, served and cleared by the receiver
  bit tx_gapless;  // current stream goes out back to back

  in_word_t   text_q[$];  // bytes of the stream being sent
  logic [2:0] enc_seq [8] = '{ENC_U16BE, ENC_UTF8_BOM, ENC_U32LE, ENC_DROP6,
                              ENC_UTF8, ENC_U16LE, ENC_U32BE, ENC_DROP7};

  always #1 clk = ~clk;

  utf_transcoder_bom_detect dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [7:0] in_byte
    .s_tlast   (s_tlast),     // in_last
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [7:0] out_byte
    .m_tlast   (m_tlast)      // out_last
  );

  utfbom_scoreboard scoreboard (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  // Watchdog counts cycles in which no word moves on either side and no register
  // write happens; a healthy run never gets near the limit, the long hold-off included.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (!rst && s_tvalid && s_tready) begin
      in_count <= in_count + 1;
      if (s_tlast) stream_count <= stream_count + 1;
    end
    if (!rst && m_tvalid && m_tready) out_count <= out_count + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Sender: random gap before each word, none while the stream is flagged gapless
  // or the receiver is asked to hold off. tvalid stays up between back-to-back
  // words, never dropped and raised in one step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = (tx_gapless || hold_req) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w.data;
    s_tlast  <= w.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic put(input logic [7:0] b, input logic last);
    in_word_t w;
    w.data = b;
    w.last = last;
    send_word(w);
  endtask

  // Wait for every predicted word to come out, then let the pipe drain, since the
  // last input words may have produced nothing yet still be in it.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_encoding(input logic [2:0] enc);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= enc;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Build one random stream into text_q. Mostly well-formed: an optional mark of
  // any of the five kinds, then characters in the matching form, sometimes cut
  // short, which can leave the last unit partial. The rest is raw noise.
  task automatic queue_stream();
    logic [7:0]  raw[$];
    logic [15:0] cp;
    logic [2:0]  mode;
    in_word_t    w;
    int          k;
    int          nchar;
    int          mark;
    raw.delete();
    tx_gapless = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 2) begin
      nchar = $urandom_range(1, 8);
      for (k = 0; k < nchar; k++) raw.push_back(8'($urandom_range(0, 255)));
    end else begin
      mark = $urandom_range(0, 5);
      mode = MODE_UTF8;
      case (mark)
        1: begin
          raw.push_back(8'hEF); raw.push_back(8'hBB); raw.push_back(8'hBF);
        end
        2: begin
          raw.push_back(8'hFF); raw.push_back(8'hFE); raw.push_back(8'h00);
          raw.push_back(8'h00);
          mode = MODE_U32LE;
        end
        3: begin
          raw.push_back(8'h00); raw.push_back(8'h00); raw.push_back(8'hFE);
          raw.push_back(8'hFF);
          mode = MODE_U32BE;
        end
        4: begin
          raw.push_back(8'hFF); raw.push_back(8'hFE);
          mode = MODE_U16LE;
        end
        5: begin
          raw.push_back(8'hFE); raw.push_back(8'hFF);
          mode = MODE_U16BE;
        end
        default: ;
      endcase
      nchar = $urandom_range(0, 6);
      for (k = 0; k < nchar; k++) begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 16'h7F));
          1:       cp = 16'($urandom_range(16'h80, 16'h7FF));
          default: cp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        case (mode)
          MODE_UTF8: begin
            if (cp[10:0] < 11'h080) begin
              raw.push_back({1'b0, cp[6:0]});
            end else begin
              raw.push_back({3'b110, cp[10:6]});
              raw.push_back({2'b10, cp[5:0]});
            end
          end
          MODE_U16LE: begin
            raw.push_back(cp[7:0]); raw.push_back(cp[15:8]);
          end
          MODE_U16BE: begin
            raw.push_back(cp[15:8]); raw.push_back(cp[7:0]);
          end
          MODE_U32LE: begin
            // upper half is ignored by the block, so put junk there at times
            raw.push_back(cp[7:0]); raw.push_back(cp[15:8]);
            raw.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'h00);
            raw.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'h00);
          end
          default: begin
            raw.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'h00);
            raw.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) : 8'h00);
            raw.push_back(cp[15:8]); raw.push_back(cp[7:0]);
          end
        endcase
      end
      // broken tail: drop the final byte, which can leave a partial last unit to be zero-padded
      if (raw.size() > 1 && $urandom_range(0, 3) == 0) void'(raw.pop_back());
    end
    if (raw.size() == 0) raw.push_back(8'($urandom_range(0, 255)));
    for (k = 0; k < raw.size(); k++) begin
      w.data = raw[k];
      w.last = (k == raw.size() - 1);
      text_q.push_back(w);
    end
  endtask

  // Receiver: random stall before each word, with every third run of 32 words taken
  // with no stall. A hold-off request is served once, right after a word is taken,
  // by keeping tready low for HOLD_CYCLES.
  initial begin : receiver
    int wait_n;
    int served;
    served = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      wait_n = ((served / 32) % 3 == 2) ? 0 : $urandom_range(0, 15);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      served++;
    end
  end

  initial begin : stimulus
    int p;
    int sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed streams.
    // Reset encoding (UTF-8), no mark: both ends of the ASCII range, a two-byte
    // character, then a lone lead byte that ends the stream and gets zero-padded.
    put(8'h00, 1'b0);
    put(8'h7F, 1'b0);
    put(8'hC3, 1'b0);
    put(8'hA9, 1'b0);
    put(8'hFF, 1'b1);
    // UTF-8 mark in, UTF-32BE out; the fourth window byte is a partial unit
    set_encoding(ENC_U32BE);
    put(8'hEF, 1'b0);
    put(8'hBB, 1'b0);
    put(8'hBF, 1'b0);
    put(8'h80, 1'b1);
    // UTF-32LE mark wins over UTF-16LE; one byte of a unit, then end of stream
    set_encoding(ENC_U16LE);
    put(8'hFF, 1'b0);
    put(8'hFE, 1'b0);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h41, 1'b1);
    // stream ends after two bytes: detection fires early on a UTF-16BE mark
    set_encoding(ENC_UTF8_BOM);
    put(8'hFE, 1'b0);
    put(8'hFF, 1'b1);
    // UTF-16LE mark with a character past 11 bits, so UTF-8 output drops bits
    put(8'hFF, 1'b0);
    put(8'hFE, 1'b0);
    put(8'h34, 1'b0);
    put(8'h12, 1'b1);
    // UTF-32BE mark with the drop-all code: no output at all
    set_encoding(ENC_DROP7);
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'hFE, 1'b0);
    put(8'hFF, 1'b1);

    // Random part: one phase per encoding code. Streams run across phase edges, so
    // some register writes land mid-stream while the block is idle.
    for (p = 0; p < 8; p++) begin
      set_encoding(enc_seq[p]);
      // UTF-32LE output makes four bytes of each character: a good phase to fill the block
      if (enc_seq[p] == ENC_U32LE) hold_req = 1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (text_q.size() == 0) queue_stream();
        send_word(text_q.pop_front());
        sent++;
      end
    end
    while (text_q.size() != 0) send_word(text_q.pop_front());
    settle();

    $display("Run covered %0d input words in %0d streams and %0d output words,", in_count,
             stream_count, out_count);
    $display("with all five input marks, all eight encoding codes and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/utfbom_pkg.sv
rtl/utfbom_front.sv
rtl/utfbom_serial.sv
rtl/utf_transcoder_bom_detect.sv
verif/utfbom_scoreboard.sv
verif/tb_utf_transcoder_bom_detect.sv
